// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by dcq_front and dcq_back.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dcq_pkg.sv =====
// ----------------------------------------------------------------------------
// dcq_pkg
// Types, codes and defaults shared by the delayed command queue.
// ----------------------------------------------------------------------------
package dcq_pkg;

    localparam int DCQ_QUEUE_DEPTH  = 64;
    localparam int DCQ_COMMAND_BITS = 16;
    localparam int DCQ_TIME_BITS    = 32;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] delay_ms;
        logic [15:0] command_id;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_command;
        logic        push_dropped;
        logic        all_idle;
        logic [6:0]  queued_count;
    } t_result;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    // stamp is the delay for a push and the current time for a tick
    typedef struct packed {
        t_op         op;
        logic [15:0] cmd;
        logic [31:0] stamp;
    } t_op_item;

    typedef struct packed {
        logic     valid;
        t_op_item item;
    } t_link;

endpackage

// ===== rtl/dcq_front.sv =====
// ----------------------------------------------------------------------------
// dcq_front
// Accepts request items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcq_front
    import dcq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_req  i_req,
    output logic  o_busy,
    input  logic  i_pop,
    output t_link o_link
);

    t_op_item   r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       w_push;
    t_op_item   w_item;

    assign o_busy = (r_count == 2'd2);
    assign w_push = i_start && !o_busy;

    always_comb begin
        w_item.cmd = i_req.command_id;
        unique case (i_req.req_type)
            REQ_PUSH: begin
                w_item.op    = OP_PUSH;
                w_item.stamp = i_req.delay_ms;
            end
            REQ_TICK: begin
                w_item.op    = OP_TICK;
                w_item.stamp = i_req.now_ms;
            end
            REQ_CLEAR: begin
                w_item.op    = OP_CLEAR;
                w_item.stamp = i_req.now_ms;
            end
            default: begin
                w_item.op    = OP_STATUS;
                w_item.stamp = i_req.now_ms;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            priority case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_link.valid = (r_count != 2'd0);
    assign o_link.item  = r_q[r_rp];

    `ASSERT_ALWAYS(a_front_no_underflow, i_clk, i_rst_n, !i_pop || (r_count != 2'd0))
    `ASSERT_ALWAYS(a_front_count_range, i_clk, i_rst_n, r_count != 2'd3)

endmodule

// ===== rtl/dcq_back.sv =====
// ----------------------------------------------------------------------------
// dcq_back
// Executes queued requests: entry memory, pending slot and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcq_back
    import dcq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DCQ_QUEUE_DEPTH,
    parameter int COMMAND_BITS = DCQ_COMMAND_BITS,
    parameter int TIME_BITS    = DCQ_TIME_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_link   i_link,
    output logic    o_pop,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW   = COMMAND_BITS + TIME_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    t_op_item                r_cur;
    logic [EW-1:0]           r_mem [QUEUE_DEPTH];
    logic [EW-1:0]           r_rd_data;
    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_tail, n_tail;
    logic [CNTW-1:0]         r_count, n_count;
    logic                    r_pend_v, n_pend_v;
    logic [COMMAND_BITS-1:0] r_pend_cmd, n_pend_cmd;
    logic [TIME_BITS-1:0]    r_pend_due, n_pend_due;
    logic                    r_done;
    t_result                 r_result, n_result;
    logic                    w_wr_en;
    logic [EW-1:0]           w_wr_data;
    logic [TIME_BITS-1:0]    w_now;
    logic [TIME_BITS:0]      w_sum;
    logic [TIME_BITS-1:0]    w_due_new;
    logic                    w_fire;

    assign o_pop     = (r_state == S_IDLE) && i_link.valid;
    assign w_now     = TIME_BITS'(r_cur.stamp);
    assign w_sum     = {1'b0, w_now} + {1'b0, r_rd_data[TIME_BITS-1:0]};
    assign w_due_new = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];
    assign w_fire    = r_pend_v && (r_pend_due <= w_now);
    assign w_wr_data = {COMMAND_BITS'(r_cur.cmd), TIME_BITS'(r_cur.stamp)};

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_pend_v   = r_pend_v;
        n_pend_cmd = r_pend_cmd;
        n_pend_due = r_pend_due;
        w_wr_en    = 1'b0;
        n_result   = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (i_link.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state                = S_IDLE;
                n_result.fired         = 1'b0;
                n_result.fired_command = '0;
                n_result.push_dropped  = 1'b0;
                unique case (r_cur.op)
                    OP_PUSH: begin
                        if (r_count == CNTW'(QUEUE_DEPTH)) begin
                            n_result.push_dropped = 1'b1;
                        end else begin
                            w_wr_en = 1'b1;
                            n_tail  = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_TICK: begin
                        if (w_fire) begin
                            n_result.fired         = 1'b1;
                            n_result.fired_command = 16'(r_pend_cmd);
                        end
                        if (!r_pend_v || w_fire) begin
                            if (r_count != '0) begin
                                n_pend_v   = 1'b1;
                                n_pend_cmd = r_rd_data[EW-1:TIME_BITS];
                                n_pend_due = w_due_new;
                                n_head     = (r_head == AW'(QUEUE_DEPTH - 1)) ?
                                             '0 : r_head + 1'b1;
                                n_count    = r_count - 1'b1;
                            end else begin
                                n_pend_v   = 1'b0;
                                n_pend_cmd = '0;
                                n_pend_due = '0;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_head     = '0;
                        n_tail     = '0;
                        n_count    = '0;
                        n_pend_v   = 1'b0;
                        n_pend_cmd = '0;
                        n_pend_due = '0;
                    end
                    default: begin
                    end
                endcase
                n_result.all_idle     = (n_count == '0) && !n_pend_v;
                n_result.queued_count = 7'(n_count);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_tail] <= w_wr_data;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[r_head];
            r_cur     <= i_link.item;
        end
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_pend_v   <= 1'b0;
            r_pend_cmd <= '0;
            r_pend_due <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_pend_v   <= n_pend_v;
            r_pend_cmd <= n_pend_cmd;
            r_pend_due <= n_pend_due;
            r_done     <= (r_state == S_EXEC);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `ASSERT_ALWAYS(a_back_count_range, i_clk, i_rst_n, r_count <= CNTW'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_back_exec_done, i_clk, i_rst_n, r_state == S_EXEC, r_done)
    `ASSERT_ALWAYS(a_back_fired_zero, i_clk, i_rst_n,
        !r_done || r_result.fired || (r_result.fired_command == '0))
    `ASSERT_ALWAYS(a_back_idle_match, i_clk, i_rst_n,
        !r_done || (r_result.all_idle == ((r_count == '0) && !r_pend_v)))

endmodule

// ===== rtl/delayed_command_queue.sv =====
// ----------------------------------------------------------------------------
// delayed_command_queue: FIFO of timed commands with one pending slot
// Path: front queue, current item register, execute state, done and result registers.
// The back end takes no new item until it has executed the one before.
// Results cannot be stalled; reset clears state, pointers, counts, pending slot and done only.
// ----------------------------------------------------------------------------
module delayed_command_queue
    import dcq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DCQ_QUEUE_DEPTH,
    parameter int COMMAND_BITS = DCQ_COMMAND_BITS,
    parameter int TIME_BITS    = DCQ_TIME_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    t_link w_link;
    logic  w_pop;

    dcq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .i_pop   (w_pop),
        .o_link  (w_link)
    );

    dcq_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .COMMAND_BITS (COMMAND_BITS),
        .TIME_BITS    (TIME_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (w_link),
        .o_pop    (w_pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: delayed command queue testbench
// Drives push, tick, clear and status items through the start/busy handshake
// and checks each done strobe in order against a predictor of the timed FIFO
// and its pending slot, or a typed row's own result. Directed items from a
// short table come first, then random pushes, tick runs, clears and noise.
// ----------------------------------------------------------------------------
module tb_top;
    import dcq_pkg::*;

    localparam int N_RANDOM  = 1400;
    localparam int CALM_TAIL = 200;

    typedef struct {
        t_req    req;
        bit      typed;
        t_result want;
    } t_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_req    i_req = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // predictor state
    logic [15:0] q_cmd [DCQ_QUEUE_DEPTH];
    logic [31:0] q_delay [DCQ_QUEUE_DEPTH];
    int          q_head = 0;
    int          q_tail = 0;
    int          q_count = 0;
    logic        pend_valid = 1'b0;
    logic [15:0] pend_cmd = '0;
    logic [31:0] pend_due = '0;

    t_result expected_results[$];
    t_result predicted;
    bit      row_typed = 1'b0;
    t_result row_result = '0;
    bit      idle_ok = 1'b1;
    int      n_errors = 0;

    delayed_command_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_req make_req(t_op op, logic [31:0] delay, logic [15:0] cmd,
                                      logic [31:0] now);
        t_req r;
        r.req_type   = op;
        r.delay_ms   = delay;
        r.command_id = cmd;
        r.now_ms     = now;
        return r;
    endfunction

    function automatic t_result make_res(logic fired, logic [15:0] cmd, logic dropped,
                                         logic idle, logic [6:0] count);
        t_result res;
        res.fired         = fired;
        res.fired_command = cmd;
        res.push_dropped  = dropped;
        res.all_idle      = idle;
        res.queued_count  = count;
        return res;
    endfunction

    function automatic t_result predict_dcq_result(t_req r);
        t_result     res;
        logic [32:0] sum;
        res = '0;
        unique case (t_op'(r.req_type))
            OP_PUSH: begin
                if (q_count >= DCQ_QUEUE_DEPTH) begin
                    res.push_dropped = 1'b1;
                end else begin
                    q_cmd[q_tail]   = r.command_id;
                    q_delay[q_tail] = r.delay_ms;
                    q_tail          = (q_tail + 1) % DCQ_QUEUE_DEPTH;
                    q_count++;
                end
            end
            OP_TICK: begin
                if (pend_valid && pend_due <= r.now_ms) begin
                    res.fired         = 1'b1;
                    res.fired_command = pend_cmd;
                    pend_valid        = 1'b0;
                    pend_cmd          = '0;
                    pend_due          = '0;
                end
                if (!pend_valid && q_count > 0) begin
                    sum        = {1'b0, r.now_ms} + {1'b0, q_delay[q_head]};
                    pend_valid = 1'b1;
                    pend_cmd   = q_cmd[q_head];
                    pend_due   = sum[32] ? '1 : sum[31:0];
                    q_head     = (q_head + 1) % DCQ_QUEUE_DEPTH;
                    q_count--;
                end
            end
            OP_CLEAR: begin
                q_head     = 0;
                q_tail     = 0;
                q_count    = 0;
                pend_valid = 1'b0;
                pend_cmd   = '0;
                pend_due   = '0;
            end
            OP_STATUS: ;
        endcase
        res.all_idle     = (q_count == 0) && !pend_valid;
        res.queued_count = 7'(q_count);
        return res;
    endfunction

    task automatic check_result(t_result want, t_result got);
        if (got.fired !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, got.fired);
            n_errors++;
        end
        if (got.fired_command !== want.fired_command) begin
            $error("fired_command: expected %h, got %h", want.fired_command,
                   got.fired_command);
            n_errors++;
        end
        if (got.push_dropped !== want.push_dropped) begin
            $error("push_dropped: expected %0d, got %0d", want.push_dropped,
                   got.push_dropped);
            n_errors++;
        end
        if (got.all_idle !== want.all_idle) begin
            $error("all_idle: expected %0d, got %0d", want.all_idle, got.all_idle);
            n_errors++;
        end
        if (got.queued_count !== want.queued_count) begin
            $error("queued_count: expected %0d, got %0d", want.queued_count,
                   got.queued_count);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding");
                    n_errors++;
                end else begin
                    check_result(expected_results.pop_front(), o_result);
                end
            end
            if (start && !busy) begin
                predicted = predict_dcq_result(i_req);
                expected_results.push_back(row_typed ? row_result : predicted);
            end
        end
    end

    task automatic issue(t_req r, bit typed, t_result want);
        logic [95:0] noise;
        if (idle_ok && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                @(negedge i_clk);
                noise = {$urandom, $urandom, $urandom};
                start <= 1'b0;
                i_req <= noise[81:0];
            end
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_req      <= r;
        row_typed  = typed;
        row_result = want;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [31:0] rand_delay();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(0, 16);
        if (pick < 9) return $urandom_range(0, 1000);
        return $urandom;
    endfunction

    initial begin
        t_row        rows[$];
        t_req        r;
        logic [95:0] rnd;
        logic [31:0] now_t;
        int          n_rand;
        int          kind;
        int          len;

        rows.push_back('{make_req(OP_TICK, 0, 0, 0), 1, make_res(0, 0, 0, 1, 0)});
        rows.push_back('{make_req(OP_STATUS, 32'h1357_9bdf, 16'hbeef, 32'h2468_ace0), 1,
                         make_res(0, 0, 0, 1, 0)});
        rows.push_back('{make_req(OP_CLEAR, 0, 0, 0), 1, make_res(0, 0, 0, 1, 0)});
        rows.push_back('{make_req(OP_PUSH, 0, 16'hffff, 0), 1, make_res(0, 0, 0, 0, 1)});
        rows.push_back('{make_req(OP_PUSH, 32'hffff_ffff, 16'h0000, 0), 1,
                         make_res(0, 0, 0, 0, 2)});
        rows.push_back('{make_req(OP_TICK, 0, 0, 0), 1, make_res(0, 0, 0, 0, 1)});
        rows.push_back('{make_req(OP_TICK, 0, 0, 0), 1, make_res(1, 16'hffff, 0, 0, 0)});
        rows.push_back('{make_req(OP_TICK, 0, 0, 32'hffff_fffe), 0, '0});
        rows.push_back('{make_req(OP_TICK, 0, 0, 32'hffff_ffff), 1,
                         make_res(1, 0, 0, 1, 0)});
        // due times past the top of the time range saturate
        rows.push_back('{make_req(OP_PUSH, 32'h20, 16'h1234, 0), 0, '0});
        rows.push_back('{make_req(OP_PUSH, 32'h5, 16'h5678, 0), 0, '0});
        rows.push_back('{make_req(OP_TICK, 0, 0, 32'hffff_fff0), 0, '0});
        rows.push_back('{make_req(OP_TICK, 0, 0, 32'hffff_ffff), 0, '0});
        rows.push_back('{make_req(OP_TICK, 0, 0, 32'h7fff_ffff), 0, '0});
        rows.push_back('{make_req(OP_CLEAR, 0, 0, 0), 1, make_res(0, 0, 0, 1, 0)});
        rows.push_back('{make_req(OP_PUSH, 32'h5555_5555, 16'haaaa, 32'haaaa_aaaa), 0, '0});
        rows.push_back('{make_req(OP_PUSH, 32'haaaa_aaaa, 16'h5555, 32'h5555_5555), 0, '0});
        rows.push_back('{make_req(OP_TICK, 32'hffff_ffff, 16'hffff, 32'haaaa_aaaa), 0, '0});
        rows.push_back('{make_req(OP_STATUS, 32'hffff_ffff, 16'hffff, 32'hffff_ffff), 0,
                         '0});
        rows.push_back('{make_req(OP_TICK, 0, 0, 32'hffff_ffff), 0, '0});
        rows.push_back('{make_req(OP_PUSH, 1, 16'h0001, 0), 0, '0});
        rows.push_back('{make_req(OP_CLEAR, 32'hffff_ffff, 16'hffff, 32'hffff_ffff), 1,
                         make_res(0, 0, 0, 1, 0)});
        rows.push_back('{make_req(OP_TICK, 0, 0, 32'h1234_5678), 1,
                         make_res(0, 0, 0, 1, 0)});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) issue(rows[k].req, rows[k].typed, rows[k].want);

        now_t  = $urandom_range(0, 1000);
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            kind = (n_rand == 0) ? 0 : $urandom_range(0, 9);
            if (kind < 3) begin
                len = (n_rand == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                                 : $urandom_range(1, 6);
                repeat (len) begin
                    idle_ok = n_rand < N_RANDOM - CALM_TAIL;
                    issue(make_req(OP_PUSH, rand_delay(), 16'($urandom), $urandom), 0, '0);
                    n_rand++;
                end
            end else if (kind < 8) begin
                len = $urandom_range(1, 12);
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0) now_t = $urandom;
                    else now_t = now_t + $urandom_range(0, 6);
                    idle_ok = n_rand < N_RANDOM - CALM_TAIL;
                    issue(make_req(OP_TICK, $urandom, 16'($urandom), now_t), 0, '0);
                    n_rand++;
                end
            end else if (kind == 8) begin
                idle_ok = n_rand < N_RANDOM - CALM_TAIL;
                issue(make_req(OP_CLEAR, $urandom, 16'($urandom), $urandom), 0, '0);
                n_rand++;
            end else begin
                rnd     = {$urandom, $urandom, $urandom};
                r       = rnd[81:0];
                idle_ok = n_rand < N_RANDOM - CALM_TAIL;
                issue(r, 0, '0);
                n_rand++;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
